[sv/stma_pkg.sv]
// shared codes, widths and controller/datapath signal groups for the triplet merge adder
package stma_pkg;

  // payload field widths
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SUM_W   = 33;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN    = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start_run;
    logic emit;
  } stma_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic slot_free;
    logic last_step;
  } stma_status_t;

endpackage

[sv/stma_in_if.sv]
// request channel: valid/ready handshake with one triplet load or run request
interface stma_in_if;
  logic                               valid;
  logic                               ready;
  logic [stma_pkg::REQ_W-1:0]         req_type;
  logic [stma_pkg::FIELD_W-1:0]       row_index;
  logic [stma_pkg::FIELD_W-1:0]       col_index;
  logic signed [stma_pkg::VAL_W-1:0]  elem_value;

  modport source (output valid, req_type, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, req_type, row_index, col_index, elem_value, output ready);
endinterface

[sv/stma_out_if.sv]
// result channel: valid/ready handshake with one merged triplet
interface stma_out_if;
  logic                               valid;
  logic                               ready;
  logic [stma_pkg::FIELD_W-1:0]       out_row;
  logic [stma_pkg::FIELD_W-1:0]       out_col;
  logic signed [stma_pkg::SUM_W-1:0]  out_value;
  logic                               last;
  logic                               empty_res;
  logic                               overflow;

  modport source (output valid, out_row, out_col, out_value, last, empty_res, overflow,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, empty_res, overflow,
                  output ready);
endinterface

[sv/stma_ctrl.sv]
// controller state machine: accepts requests and paces the merge steps
module stma_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [stma_pkg::REQ_W-1:0]  in_req_type,
  output logic                        in_ready,
  input  stma_pkg::stma_status_t      status,
  output stma_pkg::stma_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_MERGE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_req_type)
            stma_pkg::REQ_LOAD_A: cmd.load_a = 1'b1;
            stma_pkg::REQ_LOAD_B: cmd.load_b = 1'b1;
            stma_pkg::REQ_RUN: begin
              cmd.start_run = 1'b1;
              state_nxt     = S_MERGE;
            end
            default: ;
          endcase
        end
      end
      S_MERGE: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (status.last_step) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[sv/stma_datapath.sv]
// datapath: list stores, counts, merge pointers, compare/add and result register
module stma_datapath #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  stma_pkg::stma_cmd_t                cmd,
  output stma_pkg::stma_status_t             status,
  input  logic [stma_pkg::FIELD_W-1:0]       in_row_index,
  input  logic [stma_pkg::FIELD_W-1:0]       in_col_index,
  input  logic signed [stma_pkg::VAL_W-1:0]  in_elem_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [stma_pkg::FIELD_W-1:0]       out_row,
  output logic [stma_pkg::FIELD_W-1:0]       out_col,
  output logic signed [stma_pkg::SUM_W-1:0]  out_value,
  output logic                               out_last,
  output logic                               out_empty_res,
  output logic                               out_overflow
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned KEY_W = 2 * INDEX_BITS;

  // list stores, no reset: entries are used only below the fill count
  logic [INDEX_BITS-1:0]             a_row_r [MAX_ENTRIES];
  logic [INDEX_BITS-1:0]             a_col_r [MAX_ENTRIES];
  logic [stma_pkg::VAL_W-1:0]        a_val_r [MAX_ENTRIES];
  logic [INDEX_BITS-1:0]             b_row_r [MAX_ENTRIES];
  logic [INDEX_BITS-1:0]             b_col_r [MAX_ENTRIES];
  logic [stma_pkg::VAL_W-1:0]        b_val_r [MAX_ENTRIES];

  logic [CNT_W-1:0] count_a_r, count_a_nxt;
  logic [CNT_W-1:0] count_b_r, count_b_nxt;
  logic [CNT_W-1:0] ptr_a_r, ptr_a_nxt;
  logic [CNT_W-1:0] ptr_b_r, ptr_b_nxt;
  logic             dropped_r, dropped_nxt;
  logic             full_a, full_b;

  logic                               out_valid_r, out_valid_nxt;
  logic [stma_pkg::FIELD_W-1:0]       out_row_r;
  logic [stma_pkg::FIELD_W-1:0]       out_col_r;
  logic signed [stma_pkg::SUM_W-1:0]  out_value_r;
  logic                               out_last_r;
  logic                               out_empty_r;
  logic                               out_ovf_r;

  logic                               a_avail, b_avail, take_a, take_b;
  logic [KEY_W-1:0]                   key_a, key_b;
  logic [INDEX_BITS-1:0]              head_a_row, head_a_col, head_b_row, head_b_col;
  logic [stma_pkg::VAL_W-1:0]         head_a_val, head_b_val;
  logic signed [stma_pkg::SUM_W-1:0]  add_a, add_b, step_sum;
  logic                               a_done_after, b_done_after, step_last, step_empty;
  logic [INDEX_BITS-1:0]              step_row, step_col;

  assign full_a = (count_a_r == CNT_W'(MAX_ENTRIES));
  assign full_b = (count_b_r == CNT_W'(MAX_ENTRIES));

  // append into the stores
  always_ff @(posedge clk) begin
    if (cmd.load_a && !full_a) begin
      a_row_r[count_a_r[IDX_W-1:0]] <= in_row_index[INDEX_BITS-1:0];
      a_col_r[count_a_r[IDX_W-1:0]] <= in_col_index[INDEX_BITS-1:0];
      a_val_r[count_a_r[IDX_W-1:0]] <= in_elem_value;
    end
    if (cmd.load_b && !full_b) begin
      b_row_r[count_b_r[IDX_W-1:0]] <= in_row_index[INDEX_BITS-1:0];
      b_col_r[count_b_r[IDX_W-1:0]] <= in_col_index[INDEX_BITS-1:0];
      b_val_r[count_b_r[IDX_W-1:0]] <= in_elem_value;
    end
  end

  // list heads at the merge pointers
  assign head_a_row = a_row_r[ptr_a_r[IDX_W-1:0]];
  assign head_a_col = a_col_r[ptr_a_r[IDX_W-1:0]];
  assign head_a_val = a_val_r[ptr_a_r[IDX_W-1:0]];
  assign head_b_row = b_row_r[ptr_b_r[IDX_W-1:0]];
  assign head_b_col = b_col_r[ptr_b_r[IDX_W-1:0]];
  assign head_b_val = b_val_r[ptr_b_r[IDX_W-1:0]];

  // merge step: compare positions and pick one or both heads, or none when both lists are exhausted
  always_comb begin
    a_avail = (ptr_a_r < count_a_r);
    b_avail = (ptr_b_r < count_b_r);
    key_a   = {head_a_row, head_a_col};
    key_b   = {head_b_row, head_b_col};
    take_a  = 1'b0;
    take_b  = 1'b0;
    if (a_avail && b_avail) begin
      if (key_a == key_b) begin
        take_a = 1'b1;
        take_b = 1'b1;
      end else if (key_a > key_b) begin
        take_b = 1'b1;
      end else begin
        take_a = 1'b1;
      end
    end else begin
      take_a = a_avail;
      take_b = b_avail;
    end
    add_a    = take_a ? {head_a_val[stma_pkg::VAL_W-1], head_a_val} : '0;
    add_b    = take_b ? {head_b_val[stma_pkg::VAL_W-1], head_b_val} : '0;
    step_sum = add_a + add_b;
    step_row = take_a ? head_a_row : head_b_row;
    step_col = take_a ? head_a_col : head_b_col;
    a_done_after = take_a ? (ptr_a_r + CNT_W'(1) == count_a_r) : !a_avail;
    b_done_after = take_b ? (ptr_b_r + CNT_W'(1) == count_b_r) : !b_avail;
    step_empty = !a_avail && !b_avail;
    step_last  = a_done_after && b_done_after;
  end

  assign status.slot_free = !out_valid_r || out_ready;
  assign status.last_step = step_last;

  // counts, pointers and dropped flag
  always_comb begin
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    ptr_a_nxt   = ptr_a_r;
    ptr_b_nxt   = ptr_b_r;
    dropped_nxt = dropped_r;
    if (cmd.load_a) begin
      if (full_a) dropped_nxt = 1'b1;
      else        count_a_nxt = count_a_r + CNT_W'(1);
    end
    if (cmd.load_b) begin
      if (full_b) dropped_nxt = 1'b1;
      else        count_b_nxt = count_b_r + CNT_W'(1);
    end
    if (cmd.start_run) begin
      ptr_a_nxt = '0;
      ptr_b_nxt = '0;
    end
    if (cmd.emit) begin
      if (take_a) ptr_a_nxt = ptr_a_r + CNT_W'(1);
      if (take_b) ptr_b_nxt = ptr_b_r + CNT_W'(1);
      if (step_last) begin
        count_a_nxt = '0;
        count_b_nxt = '0;
        dropped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
      count_b_r <= '0;
      ptr_a_r   <= '0;
      ptr_b_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
      ptr_a_r   <= ptr_a_nxt;
      ptr_b_r   <= ptr_b_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // result register
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= step_empty ? '0 : stma_pkg::FIELD_W'(step_row);
      out_col_r   <= step_empty ? '0 : stma_pkg::FIELD_W'(step_col);
      out_value_r <= step_sum;
      out_last_r  <= step_last;
      out_empty_r <= step_empty;
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;
  assign out_overflow  = out_ovf_r;

endmodule

[sv/sparse_triplet_merge_add_core.sv]
// top level of the sparse triplet merge adder
//
// Usage: requests arrive on in_if (valid/ready). A request with req_type
// load A or load B appends (row, col, value) to list A or B; each list holds
// MAX_ENTRIES triplets and loads into a full list are dropped, which marks
// the overflow bit on the results of the next run. A run request merges both
// lists by (row, col) and sends the merged triplets on out_if, with last set
// on the final one; equal positions give one triplet with the 33-bit sum.
// An empty run gives a single result with empty_res and last set.
// Timing: a run request moves the controller into the merge state, where
// each compare/add step is registered in the output register before it is
// shown on out_if; one result per cycle follows while the receiver does not
// stall. No request is taken while a run is merging; the next one is taken
// as soon as the last result sits in the output register.
// Reset clears both counts, the overflow flag and the output valid; the list
// stores are not cleared. When the receiver stalls, the output register holds
// its result and the merge waits.
module sparse_triplet_merge_add_core #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  stma_in_if.sink    in_if,
  stma_out_if.source out_if
);

  stma_pkg::stma_cmd_t    cmd;
  stma_pkg::stma_status_t status;

  // request pacing
  stma_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_req_type (in_if.req_type),
    .in_ready    (in_if.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // stores, merge step and result register
  stma_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .INDEX_BITS  (INDEX_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_row_index  (in_if.row_index),
    .in_col_index  (in_if.col_index),
    .in_elem_value (in_if.elem_value),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_row       (out_if.out_row),
    .out_col       (out_if.out_col),
    .out_value     (out_if.out_value),
    .out_last      (out_if.last),
    .out_empty_res (out_if.empty_res),
    .out_overflow  (out_if.overflow)
  );

endmodule

[sv/stma_checker.sv]
// port-level checks for the triplet merge adder, bound to the top level
module stma_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [stma_pkg::REQ_W-1:0]         in_req_type,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [stma_pkg::FIELD_W-1:0]       out_row,
  input logic [stma_pkg::FIELD_W-1:0]       out_col,
  input logic signed [stma_pkg::SUM_W-1:0]  out_value,
  input logic                               out_last,
  input logic                               out_empty_res
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_row)
      && $stable(out_col) && $stable(out_last))
    else $error("stalled result changed");

  // an empty result is the only and last result, with zero fields
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && out_row == '0 && out_col == '0
      && out_value == '0)
    else $error("empty result malformed");

  // no request is taken right after a run request
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == stma_pkg::REQ_RUN |=> !in_ready)
    else $error("request taken during merge");

  // a load never raises a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type != stma_pkg::REQ_RUN && !out_valid |=> !out_valid)
    else $error("result appeared after a load");

endmodule

bind sparse_triplet_merge_add_core stma_checker u_stma_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_req_type   (in_if.req_type),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_row       (out_if.out_row),
  .out_col       (out_if.out_col),
  .out_value     (out_if.out_value),
  .out_last      (out_if.last),
  .out_empty_res (out_if.empty_res)
);
